>>> hdl/trgs_pkg.sv
`timescale 1ns / 1ps

package trgs_pkg;

  // Network dimensions
  localparam int HIDDEN_TRITS   = 16;
  localparam int EXTERNAL_TRITS = 32;
  localparam int CAT_W          = EXTERNAL_TRITS + HIDDEN_TRITS;

  // Port field widths
  localparam int NEURON_W  = 4;
  localparam int ROW_W     = 48;
  localparam int EXT_W     = 32;
  localparam int COUNT_W   = 32;
  localparam int DECISION_W = 2;

  // Running vote spans -HIDDEN_TRITS .. +HIDDEN_TRITS
  localparam int VOTE_W = $clog2(HIDDEN_TRITS + 1) + 1;
  // Match counters over the concatenated vector
  localparam int CNT_W  = $clog2(CAT_W + 1);

  // Input codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_STEP  = 1'b1;
  localparam logic PATH_GATE = 1'b0;
  localparam logic PATH_CAND = 1'b1;

  // Decision codes
  localparam logic signed [DECISION_W-1:0] DEC_POS  = 2'sb01;
  localparam logic signed [DECISION_W-1:0] DEC_ZERO = 2'sb00;
  localparam logic signed [DECISION_W-1:0] DEC_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // One trit as a plus and a minus flag
  typedef struct packed {
    logic p;
    logic m;
  } trit_t;

  // Row write command for one cell
  typedef struct packed {
    logic             gate_we;
    logic             cand_we;
    logic [CAT_W-1:0] plus;
    logic [CAT_W-1:0] minus;
  } row_wr_t;

  // Step token that walks down the chain
  typedef struct packed {
    logic                     vld;
    logic [CAT_W-1:0]         xp;
    logic [CAT_W-1:0]         xm;
    logic signed [VOTE_W-1:0] vote;
  } token_t;

endpackage

>>> hdl/trgs_cell.sv
`timescale 1ns / 1ps

module trgs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trgs_pkg::row_wr_t wr_i,
  input  trgs_pkg::token_t  tok_i,
  output trgs_pkg::token_t  tok_o,
  output trgs_pkg::trit_t   hidden_o
);
  import trgs_pkg::*;

  logic [CAT_W-1:0] gate_p_q, gate_m_q, cand_p_q, cand_m_q;
  trit_t            hidden_q, hidden_d;
  trit_t            f_sign, g_sign;
  logic             tok_vld_q;
  logic [CAT_W-1:0] tok_xp_q, tok_xm_q;
  logic signed [VOTE_W-1:0] vote_q, vote_d;

  // Sign of a ternary dot product: matches minus mismatches
  function automatic trit_t dot_trit(input logic [CAT_W-1:0] wp, input logic [CAT_W-1:0] wm,
                                     input logic [CAT_W-1:0] xp, input logic [CAT_W-1:0] xm);
    logic [CAT_W-1:0] pos;
    logic [CAT_W-1:0] neg;
    logic [CNT_W-1:0] n_pos;
    logic [CNT_W-1:0] n_neg;
    trit_t            r;
    // a position with both flags set on either side contributes nothing
    pos = (wp & ~wm & xp & ~xm) | (wm & ~wp & xm & ~xp);
    neg = (wp & ~wm & xm & ~xp) | (wm & ~wp & xp & ~xm);
    n_pos = CNT_W'($countones(pos));
    n_neg = CNT_W'($countones(neg));
    r.p = n_pos > n_neg;
    r.m = n_neg > n_pos;
    return r;
  endfunction

  // Evaluate both pathways against the passing token
  always_comb begin
    f_sign = dot_trit(gate_p_q, gate_m_q, tok_i.xp, tok_i.xm);
    g_sign = dot_trit(cand_p_q, cand_m_q, tok_i.xp, tok_i.xm);
    if (f_sign.p) begin
      hidden_d = g_sign;
    end else if (f_sign.m) begin
      hidden_d.p = g_sign.m;
      hidden_d.m = g_sign.p;
    end else begin
      hidden_d = hidden_q;
    end
    vote_d = tok_i.vote + (hidden_d.p ? VOTE_W'(1) : VOTE_W'(0))
                        - (hidden_d.m ? VOTE_W'(1) : VOTE_W'(0));
  end

  // Store weight rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_p_q <= '0;
      gate_m_q <= '0;
      cand_p_q <= '0;
      cand_m_q <= '0;
    end else begin
      if (wr_i.gate_we) begin
        gate_p_q <= wr_i.plus;
        gate_m_q <= wr_i.minus;
      end
      if (wr_i.cand_we) begin
        cand_p_q <= wr_i.plus;
        cand_m_q <= wr_i.minus;
      end
    end
  end

  // Commit the hidden trit and hand the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidden_q  <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
      if (tok_i.vld) begin
        hidden_q <= hidden_d;
      end
    end
  end

  // Hold token payload between transactions
  always_ff @(posedge clk_i) begin
    if (tok_i.vld) begin
      tok_xp_q <= tok_i.xp;
      tok_xm_q <= tok_i.xm;
      vote_q   <= vote_d;
    end
  end

  assign tok_o.vld  = tok_vld_q;
  assign tok_o.xp   = tok_xp_q;
  assign tok_o.xm   = tok_xm_q;
  assign tok_o.vote = vote_q;
  assign hidden_o   = hidden_q;

endmodule

>>> hdl/ternary_recurrent_gate_step.sv
`timescale 1ns / 1ps
// out_valid_o rises once a step transaction is accepted and its token has passed
//   the 16-cell chain, one neuron per cycle; the FSM then enters ST_FINISH and loads the output.
// A new step is accepted only after the previous one has loaded its result; a row write gives no result.
// Input stays stalled while a step is in the chain or waits for the output register.
// Reset (rst_ni low, asynchronous): weight rows and hidden trits clear to zero,
//   the step count clears, and both channels go idle.
module ternary_recurrent_gate_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic                                  pathway_i,
  input  logic [trgs_pkg::NEURON_W-1:0]         neuron_i,
  input  logic [trgs_pkg::ROW_W-1:0]            row_plus_mask_i,
  input  logic [trgs_pkg::ROW_W-1:0]            row_minus_mask_i,
  input  logic [trgs_pkg::EXT_W-1:0]            ext_plus_mask_i,
  input  logic [trgs_pkg::EXT_W-1:0]            ext_minus_mask_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [trgs_pkg::HIDDEN_TRITS-1:0]     hidden_plus_mask_o,
  output logic [trgs_pkg::HIDDEN_TRITS-1:0]     hidden_minus_mask_o,
  output logic signed [trgs_pkg::DECISION_W-1:0] decision_o,
  output logic [trgs_pkg::COUNT_W-1:0]          steps_done_o
);
  import trgs_pkg::*;

  state_e state_q, state_d;

  token_t  tok [HIDDEN_TRITS+1];
  row_wr_t wr  [HIDDEN_TRITS];
  trit_t   hid [HIDDEN_TRITS];

  logic [HIDDEN_TRITS-1:0] hid_p, hid_m, tok_vld;
  logic                    in_acc, step_acc, write_acc, out_free, out_load;

  logic                          out_valid_q;
  logic [HIDDEN_TRITS-1:0]       out_hp_q, out_hm_q;
  logic signed [DECISION_W-1:0]  out_dec_q, dec_d;
  logic [COUNT_W-1:0]            count_q;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign step_acc  = in_acc && (action_i == ACT_STEP);
  assign write_acc = in_acc && (action_i == ACT_WRITE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Inject the step token: external trits first, then the old hidden trits
  assign tok[0].vld  = step_acc;
  assign tok[0].xp   = {hid_p, ext_plus_mask_i[EXTERNAL_TRITS-1:0]};
  assign tok[0].xm   = {hid_m, ext_minus_mask_i[EXTERNAL_TRITS-1:0]};
  assign tok[0].vote = '0;

  // Build the chain of neuron cells
  for (genvar k = 0; k < HIDDEN_TRITS; k++) begin : g_cell
    logic hit;
    assign hit           = write_acc && (neuron_i == NEURON_W'(k));
    assign wr[k].gate_we = hit && (pathway_i == PATH_GATE);
    assign wr[k].cand_we = hit && (pathway_i == PATH_CAND);
    assign wr[k].plus    = row_plus_mask_i[CAT_W-1:0];
    assign wr[k].minus   = row_minus_mask_i[CAT_W-1:0];

    trgs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr[k]),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1]),
      .hidden_o (hid[k])
    );

    assign hid_p[k]   = hid[k].p;
    assign hid_m[k]   = hid[k].m;
    assign tok_vld[k] = tok[k+1].vld;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (step_acc) state_d = ST_RUN;
      ST_RUN:    if (tok[HIDDEN_TRITS].vld) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_RUN:    in_stall_o = 1'b1;
      ST_FINISH: out_load   = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sign of the final vote
  always_comb begin
    if (tok[HIDDEN_TRITS].vote > 0) begin
      dec_d = DEC_POS;
    end else if (tok[HIDDEN_TRITS].vote < 0) begin
      dec_d = DEC_NEG;
    end else begin
      dec_d = DEC_ZERO;
    end
  end

  // Advance the step count and hold the output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q + COUNT_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hp_q  <= hid_p;
      out_hm_q  <= hid_m;
      out_dec_q <= dec_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hidden_plus_mask_o  = out_hp_q;
  assign hidden_minus_mask_o = out_hm_q;
  assign decision_o          = out_dec_q;
  assign steps_done_o        = count_q;

  // Only one step token is ever in flight
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one step token in the chain");

  // An idle block has an empty chain
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_vld == '0))
    else $error("step token in chain while idle");

  // The tail token arrives only during a running step
  a_tail_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[HIDDEN_TRITS].vld |-> (state_q == ST_RUN))
    else $error("tail token outside a running step");

  // A hidden trit is never both plus and minus
  a_hid_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hid_p & hid_m) == '0)
    else $error("hidden trit flagged plus and minus");

  // Each result advances the step count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (count_q == $past(count_q) + COUNT_W'(1)))
    else $error("step count did not advance with a result");

endmodule
